[src/rrq_pkg.sv]
// Shared types and constants for the round-robin run queue.
// Used by rrq_cell, rrq_slice_bank and round_robin_run_queue_top; no dependencies.
package rrq_pkg;

  localparam int unsigned PID_W   = 5;
  localparam int unsigned SLICE_W = 8;
  localparam int unsigned COUNT_W = 6;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAT_W  = 2;

  // Commands carried by an input item.
  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PICK = 2'd2,
    CMD_TICK = 2'd3
  } rrq_cmd_e;

  // Status codes returned with every result item.
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2
  } rrq_status_e;

  // Contents of one queue slot, handed between neighboring cells.
  typedef struct packed {
    logic             valid;
    logic [PID_W-1:0] id;
  } rrq_link_t;

  // Broadcast control that every cell sees in the same cycle.
  typedef struct packed {
    logic             enq;
    logic             deq;
    logic [PID_W-1:0] pid;
  } rrq_ctl_t;

endpackage

[src/rrq_cell.sv]
// One slot of the run queue chain: holds a process number and a valid bit.
// Depends on rrq_pkg for the link and control structs.
module rrq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rrq_pkg::rrq_ctl_t  ctl_i,
  input  logic               prev_valid_i,
  input  logic               found_i,
  input  rrq_pkg::rrq_link_t next_i,
  output rrq_pkg::rrq_link_t slot_o,
  output logic               match_o,
  output logic               found_o
);

  logic                      valid_q, valid_d;
  logic [rrq_pkg::PID_W-1:0] id_q, id_d;
  logic                      tail;

  assign match_o = valid_q && (id_q == ctl_i.pid);
  assign found_o = found_i || match_o;
  assign tail    = !valid_q && prev_valid_i;
  assign slot_o  = '{valid: valid_q, id: id_q};

  // The first empty slot takes an appended process; on a removal every slot
  // from the matching one onward takes its right neighbor's contents.
  always_comb begin
    valid_d = valid_q;
    id_d    = id_q;
    if (ctl_i.enq && tail) begin
      valid_d = 1'b1;
      id_d    = ctl_i.pid;
    end else if (ctl_i.deq && found_o) begin
      valid_d = next_i.valid;
      id_d    = next_i.id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

endmodule

[src/rrq_slice_bank.sv]
// Per-process time-slice counters, cleared by reset, one write port.
// Depends on rrq_pkg for the slice width.
module rrq_slice_bank #(
  parameter int unsigned NUM   = 32,
  parameter int unsigned IDX_W = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [IDX_W-1:0]            idx_i,
  input  logic                        wr_en_i,
  input  logic [rrq_pkg::SLICE_W-1:0] wr_data_i,
  output logic [rrq_pkg::SLICE_W-1:0] rd_data_o
);

  logic [rrq_pkg::SLICE_W-1:0] slice_q [NUM];

  // A read past the last entry returns zero.
  assign rd_data_o = (32'(idx_i) < 32'(NUM)) ? slice_q[idx_i] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(NUM); i++) begin
        slice_q[i] <= '0;
      end
    end else if (wr_en_i && (32'(idx_i) < 32'(NUM))) begin
      slice_q[idx_i] <= wr_data_i;
    end
  end

endmodule

[src/round_robin_run_queue_top.sv]
// Top level of the round-robin run queue: cell chain, slice counters, result register.
// Depends on rrq_pkg, rrq_cell and rrq_slice_bank.

// The block keeps a round-robin ready queue of process numbers together with a
// time-slice count for every process. Each input item carries a command and a
// process number and produces exactly one result item. The queue is a row of
// MAX_PROCS identical cells with the head in cell 0; an enqueue fills the first
// empty cell, and a dequeue makes every cell from the matching one onward copy
// its right neighbor in the same cycle, so the queue closes up at once. Whether
// a process is queued is found by comparing its number in all cells in
// parallel. The state is updated and the result is captured in the output
// register at the edge that accepts the item, so a new item is taken every cycle
// as long as the output side keeps taking results. The slice counters come out
// of reset at zero, and max_slice comes out of reset at 5; max_slice may be
// written only while no item is in flight.
module round_robin_run_queue_top #(
  parameter int unsigned MAX_PROCS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel: max_slice.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // Input items. tdata: command [1:0], proc_id [6:2], zero [7].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  // Result items. tdata: pick_valid [0], pick_id [5:1], resched [6],
  // ready_count [12:7], slice_left [20:13], status [22:21], zero [23].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata
);

  // Only process numbers below 32 can be named, so at most that many slices.
  localparam int unsigned NumSlices = (MAX_PROCS < 32) ? MAX_PROCS : 32;
  localparam int unsigned SliceIdxW = $clog2(NumSlices);

  localparam int unsigned PidW   = rrq_pkg::PID_W;
  localparam int unsigned SliceW = rrq_pkg::SLICE_W;
  localparam int unsigned CountW = rrq_pkg::COUNT_W;

  // Configuration register.
  logic [SliceW-1:0] max_slice_q;

  // Input decode.
  logic              in_acc;
  rrq_pkg::rrq_cmd_e cmd;
  logic [PidW-1:0]   pid;
  logic              in_range;

  // Cell chain.
  rrq_pkg::rrq_ctl_t  ctl;
  rrq_pkg::rrq_link_t slot  [MAX_PROCS];
  logic [MAX_PROCS-1:0] valid_vec;
  logic [MAX_PROCS-1:0] match_vec;
  logic [MAX_PROCS-1:0] found_vec;
  logic                 member;
  logic                 full;

  // Queue length.
  logic [CountW-1:0] count_q, count_d;

  // Slice counters.
  logic [SliceW-1:0] slice_rd;
  logic [SliceW-1:0] slice_cur;
  logic [SliceW-1:0] slice_new;
  logic              slice_we;

  // Result.
  logic                 pick_valid;
  logic [PidW-1:0]      pick_id;
  logic                 resched;
  rrq_pkg::rrq_status_e status;
  logic                 out_valid_q;
  logic [23:0]          out_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_slice_q <= SliceW'(5);
    end else if (cfg_valid_i) begin
      max_slice_q <= cfg_data_i;
    end
  end

  // An item is taken whenever the result register is free or being emptied.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign cmd      = rrq_pkg::rrq_cmd_e'(s_axis_tdata[1:0]);
  assign pid      = s_axis_tdata[6:2];
  assign in_range = 32'(pid) < 32'(MAX_PROCS);

  assign member = |match_vec;
  assign full   = valid_vec[MAX_PROCS-1];

  assign ctl.pid = pid;
  assign ctl.enq = in_acc && in_range && (cmd == rrq_pkg::CMD_ENQ) && !member && !full;
  assign ctl.deq = in_acc && in_range && (cmd == rrq_pkg::CMD_DEQ) && member;

  for (genvar i = 0; i < int'(MAX_PROCS); i++) begin : g_cell
    logic               prev_valid;
    logic               found_in;
    rrq_pkg::rrq_link_t next_slot;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign found_in   = 1'b0;
    end else begin : g_body
      assign prev_valid = valid_vec[i-1];
      assign found_in   = found_vec[i-1];
    end

    if (i == int'(MAX_PROCS) - 1) begin : g_last
      assign next_slot = '{valid: 1'b0, id: '0};
    end else begin : g_inner
      assign next_slot = slot[i+1];
    end

    rrq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .prev_valid_i (prev_valid),
      .found_i      (found_in),
      .next_i       (next_slot),
      .slot_o       (slot[i]),
      .match_o      (match_vec[i]),
      .found_o      (found_vec[i])
    );

    assign valid_vec[i] = slot[i].valid;
  end

  always_comb begin
    count_d = count_q;
    if (ctl.enq) begin
      count_d = count_q + CountW'(1);
    end else if (ctl.deq) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  rrq_slice_bank #(
    .NUM   (NumSlices),
    .IDX_W (SliceIdxW)
  ) u_slices (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .idx_i     (pid[SliceIdxW-1:0]),
    .wr_en_i   (slice_we),
    .wr_data_i (slice_new),
    .rd_data_o (slice_rd)
  );

  assign slice_cur = in_range ? slice_rd : '0;

  // Command decode: slice update, status, the reschedule flag and the pick answer.
  always_comb begin
    slice_new  = slice_cur;
    slice_we   = 1'b0;
    resched    = 1'b0;
    pick_valid = 1'b0;
    pick_id    = '0;
    status     = rrq_pkg::ST_OK;
    unique case (cmd)
      rrq_pkg::CMD_PICK: begin
        pick_valid = slot[0].valid;
        pick_id    = slot[0].valid ? slot[0].id : '0;
      end
      rrq_pkg::CMD_ENQ: begin
        if (!in_range) begin
          status = rrq_pkg::ST_ABSENT;
        end else if (member) begin
          status = rrq_pkg::ST_DUP;
        end else if (!full && (slice_cur == '0)) begin
          // A process whose slice ran out gets a fresh one on append.
          slice_new = max_slice_q;
          slice_we  = in_acc;
        end
      end
      rrq_pkg::CMD_DEQ: begin
        if (!in_range || !member) begin
          status = rrq_pkg::ST_ABSENT;
        end
      end
      rrq_pkg::CMD_TICK: begin
        if (!in_range) begin
          status = rrq_pkg::ST_ABSENT;
        end else begin
          if (slice_cur != '0) begin
            slice_new = slice_cur - SliceW'(1);
            slice_we  = in_acc;
          end
          resched = (slice_new == '0);
        end
      end
      default: begin
        status = rrq_pkg::ST_OK;
      end
    endcase
  end

  // Result register: holds an item until the output side takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_data_q <= {1'b0, status, slice_new, count_d, resched, pick_id, pick_valid};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The length register always agrees with the number of occupied cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == 32'($countones(valid_vec)))
    else $error("queue length disagrees with occupied cells");

  // Occupied cells always form a gapless run starting at the head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + MAX_PROCS'(1)) & valid_vec) == '0)
    else $error("gap in the queue cell chain");

  // Removing a queued process shortens the queue by one and drops it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.deq |=> (count_q == $past(count_q) - CountW'(1)) &&
                !(|match_vec && (ctl.pid == $past(ctl.pid))))
    else $error("dequeue did not remove the process");

endmodule

[tb/rrq_checker.sv]
`timescale 1ns / 100ps
// Result checker for the round-robin run queue: watches the config, input and result channels.
// Keeps its own copy of the queue, member flags and slice counters. Depends on rrq_pkg.
module rrq_checker
  import rrq_pkg::*;
#(
  parameter int unsigned MAX_PROCS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [7:0]        cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [7:0]        in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic [23:0]       out_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       outstanding_o
);

  localparam logic [SLICE_W-1:0] MAX_SLICE_RESET = 8'd5;

  // Result item layout, highest field first.
  typedef struct packed {
    logic               pad;
    rrq_status_e        status;
    logic [SLICE_W-1:0] slice_left;
    logic [COUNT_W-1:0] ready_count;
    logic               resched;
    logic [PID_W-1:0]   pick_id;
    logic               pick_valid;
  } reply_t;

  logic [PID_W-1:0]   slot_q  [MAX_PROCS];
  bit                 member  [MAX_PROCS];
  logic [SLICE_W-1:0] slice_q [MAX_PROCS];
  int unsigned        depth;
  logic [SLICE_W-1:0] max_slice;
  reply_t             replies_due [$];
  reply_t             want;
  reply_t             got;
  int unsigned        fails;

  // Applies one command to the shadow queue and returns the reply it should produce.
  function automatic reply_t queue_step(rrq_cmd_e cmd, logic [PID_W-1:0] pid);
    reply_t r;
    bit     hit;
    r = '0;
    r.status = ST_OK;
    if (cmd == CMD_PICK) begin
      if (depth > 0) begin
        r.pick_valid = 1'b1;
        r.pick_id = slot_q[0];
      end
    end else if (pid >= MAX_PROCS) begin
      r.status = ST_ABSENT;
    end else if (cmd == CMD_ENQ) begin
      if (member[pid]) begin
        r.status = ST_DUP;
      end else if (depth < MAX_PROCS) begin
        if (slice_q[pid] == '0) slice_q[pid] = max_slice;
        slot_q[depth] = pid;
        depth++;
        member[pid] = 1'b1;
      end
    end else if (cmd == CMD_DEQ) begin
      if (!member[pid]) begin
        r.status = ST_ABSENT;
      end else begin
        // Every entry from the removed one onward takes its successor.
        hit = 1'b0;
        for (int i = 0; i < depth; i++) begin
          if (slot_q[i] == pid) hit = 1'b1;
          if (hit && i + 1 < depth) slot_q[i] = slot_q[i+1];
        end
        if (hit) depth--;
        member[pid] = 1'b0;
      end
    end else begin
      if (slice_q[pid] != '0) slice_q[pid]--;
      r.resched = (slice_q[pid] == '0);
    end
    r.ready_count = COUNT_W'(depth);
    r.slice_left = (pid < MAX_PROCS) ? slice_q[pid] : '0;
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", field, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PROCS; i++) begin
        slot_q[i] = '0;
        member[i] = 1'b0;
        slice_q[i] = '0;
      end
      depth = 0;
      max_slice = MAX_SLICE_RESET;
      replies_due.delete();
      fails = 0;
      fail_count_o <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) max_slice = cfg_data_i;
      // Results leave before new items enter, since a result never comes back in the
      // cycle that takes its item.
      if (out_valid_i && out_ready_i) begin
        got = reply_t'(out_data_i);
        if (replies_due.size() == 0) begin
          $error("result item with no item waiting for it: tdata %h", out_data_i);
          fails++;
        end else begin
          want = replies_due.pop_front();
          check_field("pick_valid", want.pick_valid, got.pick_valid);
          check_field("pick_id", want.pick_id, got.pick_id);
          check_field("resched", want.resched, got.resched);
          check_field("ready_count", want.ready_count, got.ready_count);
          check_field("slice_left", want.slice_left, got.slice_left);
          check_field("status", want.status, got.status);
        end
      end
      if (in_valid_i && in_ready_i) begin
        replies_due.push_back(queue_step(rrq_cmd_e'(in_data_i[1:0]),
                                         in_data_i[2 +: PID_W]));
      end
      outstanding_o <= replies_due.size();
      fail_count_o <= fails;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Top of the run queue testbench: clock, reset, stimulus, result-side stalls and verdict.
// Depends on rrq_pkg, round_robin_run_queue_top and rrq_checker.
module tb_top;
  import rrq_pkg::*;

  localparam int unsigned MAX_PROCS = 32;

  // Kinds of random command bursts. Fills and drains move the queue between empty and
  // full, tick runs drive single slices down to zero, and mixed bursts add noise.
  typedef enum int unsigned {
    BURST_FILL,
    BURST_DRAIN,
    BURST_TICKS,
    BURST_MIXED
  } burst_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;    // command [1:0], proc_id [6:2], zero [7]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // pick_valid, pick_id, resched, ready_count,
                                     // slice_left, status, zero

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned tx_idle_pct = 33;
  int unsigned rx_idle_pct = 81;
  int unsigned sent = 0;

  // The clock runs with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  round_robin_run_queue_top #(
    .MAX_PROCS(MAX_PROCS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  rrq_checker #(
    .MAX_PROCS(MAX_PROCS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .out_valid_i  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_i   (m_axis_tdata),
    .fail_count_o (fail_count),
    .outstanding_o(outstanding)
  );

  // The result side stalls at random; the percentage changes between phases, and a
  // percentage of zero keeps ready high throughout.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99, 0) >= rx_idle_pct);
  end

  // Offers one item after a random number of idle cycles and returns at the edge that
  // takes it. Valid stays high on return so that back-to-back items follow without a gap.
  task automatic issue_command(input rrq_cmd_e cmd, input logic [PID_W-1:0] pid);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, pid, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
  endtask

  // Stops offering items and waits until every result has come back. The first edge
  // lets the checker count the item that was taken last.
  task automatic drain_replies();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  // Writes max_slice; only called while the queue has nothing in flight.
  task automatic set_max_slice(input logic [7:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Random bursts until the given number of further items has been taken.
  task automatic run_bursts(input int unsigned budget);
    int unsigned goal;
    int unsigned len;
    int unsigned start;
    burst_e      kind;
    logic [PID_W-1:0] pid;
    goal = sent + budget;
    while (sent < goal) begin
      kind = burst_e'($urandom_range(3, 0));
      case (kind)
        BURST_FILL: begin
          len = $urandom_range(36, 4);
          repeat (len) begin
            issue_command(CMD_ENQ, PID_W'($urandom));
            if ($urandom_range(5, 0) == 0) issue_command(CMD_PICK, PID_W'($urandom));
          end
        end
        BURST_DRAIN: begin
          // Sweep a window of process numbers so that every queued one in it goes,
          // from the head, the middle and the tail alike.
          len = $urandom_range(32, 4);
          start = $urandom_range(31, 0);
          for (int k = 0; k < len; k++) begin
            issue_command(CMD_DEQ, PID_W'(start + k));
            if ($urandom_range(3, 0) == 0) issue_command(CMD_PICK, PID_W'($urandom));
          end
        end
        BURST_TICKS: begin
          // Mostly short runs; now and then a long one that can exhaust even the largest slice.
          pid = PID_W'($urandom);
          len = ($urandom_range(7, 0) == 0) ? $urandom_range(270, 20) : $urandom_range(8, 1);
          if ($urandom_range(1, 0) == 0) issue_command(CMD_ENQ, pid);
          repeat (len) issue_command(CMD_TICK, pid);
          if ($urandom_range(1, 0) == 0) begin
            issue_command(CMD_ENQ, pid);
            issue_command(CMD_TICK, pid);
          end
        end
        default: begin
          len = $urandom_range(30, 8);
          repeat (len) issue_command(rrq_cmd_e'($urandom_range(3, 0)), PID_W'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items with max_slice still at its reset value of 5.
    issue_command(CMD_PICK, 5'd0);    // pick on an empty queue
    issue_command(CMD_TICK, 5'd3);    // tick of an unqueued process with an empty slice
    issue_command(CMD_DEQ,  5'd7);    // dequeue of a process that is not queued
    issue_command(CMD_ENQ,  5'd0);    // lowest process number, slice reloads
    issue_command(CMD_ENQ,  5'd31);   // highest process number
    issue_command(CMD_ENQ,  5'd0);    // duplicate enqueue
    issue_command(CMD_PICK, 5'd31);
    issue_command(CMD_ENQ,  5'd16);
    issue_command(CMD_DEQ,  5'd0);    // removal at the head
    issue_command(CMD_PICK, 5'd0);
    repeat (5) issue_command(CMD_TICK, 5'd31);  // last one exhausts the slice
    issue_command(CMD_TICK, 5'd31);   // tick at zero stays at zero
    issue_command(CMD_ENQ,  5'd31);   // duplicate enqueue does not reload
    issue_command(CMD_DEQ,  5'd31);
    issue_command(CMD_ENQ,  5'd31);   // fresh enqueue reloads the empty slice
    issue_command(CMD_DEQ,  5'd31);   // removal at the tail
    issue_command(CMD_DEQ,  5'd16);
    issue_command(CMD_PICK, 5'd16);
    issue_command(CMD_ENQ,  5'd21);   // left queued into the random part

    run_bursts(240);
    drain_replies();
    set_max_slice(8'd1);
    run_bursts(240);

    drain_replies();
    tx_idle_pct = 81;
    rx_idle_pct = 33;
    set_max_slice(8'd255);
    run_bursts(240);
    drain_replies();
    set_max_slice(8'd0);              // reloads then hand out an empty slice
    run_bursts(240);

    drain_replies();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_max_slice(8'($urandom_range(254, 2)));
    run_bursts(240);

    // Let any stray result show up before the verdict.
    drain_replies();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run: about 1500 items, each with long idle gaps on both sides.
  initial begin
    #8_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
